### rtl/rbpl_pkg.sv
// ---------------------------------------------------------------------------
// rbpl_pkg
// Shared widths, operation and status codes, and memory control bundles.
// ---------------------------------------------------------------------------
package rbpl_pkg;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 8;
  localparam int FILL_W   = 9;
  localparam int HASH_W   = 64;
  localparam int STATUS_W = 2;
  localparam int REFO_W   = 16;
  localparam int CNTO_W   = 9;
  localparam int EVT_W    = 32;

  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
  localparam logic [OP_W-1:0] OP_RETAIN  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET     = 3'd3;
  localparam logic [OP_W-1:0] OP_TOUCH   = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOPAGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REL_IGN = 2'd2;

  localparam logic REG_CACHE_EN  = 1'b0;
  localparam logic REG_TOKENS    = 1'b1;

  // single-port RAM control
  typedef struct packed {
    logic rd;
    logic we;
  } ram_ctl_t;

  // link RAM control: one read of both banks, or per-bank writes
  typedef struct packed {
    logic rd;
    logic prev_we;
    logic next_we;
  } link_ctl_t;

endpackage

### rtl/rbpl_in_if.sv
// ---------------------------------------------------------------------------
// rbpl_in_if
// Command channel: one item per block operation.
// ---------------------------------------------------------------------------
interface rbpl_in_if import rbpl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  block_index;
  logic [FILL_W-1:0] fill_count;
  logic [HASH_W-1:0] content_hash;

  modport source (output valid, operation, block_index, fill_count, content_hash,
                  input ready);
  modport sink   (input valid, operation, block_index, fill_count, content_hash,
                  output ready);
endinterface

### rtl/rbpl_out_if.sv
// ---------------------------------------------------------------------------
// rbpl_out_if
// Result channel: one item per command.
// ---------------------------------------------------------------------------
interface rbpl_out_if import rbpl_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    result_block;
  logic [REFO_W-1:0]   ref_after;
  logic [FILL_W-1:0]   fill_after;
  logic                cached_after;
  logic                evicted;
  logic [HASH_W-1:0]   evicted_hash;
  logic [CNTO_W-1:0]   free_count;
  logic [CNTO_W-1:0]   cached_blocks;
  logic [EVT_W-1:0]    eviction_total;

  modport source (output valid, status, result_block, ref_after, fill_after,
                  cached_after, evicted, evicted_hash, free_count, cached_blocks,
                  eviction_total, input ready);
  modport sink   (input valid, status, result_block, ref_after, fill_after,
                  cached_after, evicted, evicted_hash, free_count, cached_blocks,
                  eviction_total, output ready);
endinterface

### rtl/rbpl_blk_ram.sv
// ---------------------------------------------------------------------------
// rbpl_blk_ram
// Per-block state RAM, registered read, zeroed by a sweep after reset.
// ---------------------------------------------------------------------------
module rbpl_blk_ram import rbpl_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 90
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ram_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata,
  output logic          busy
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_cnt_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

  assign busy = busy_r;

endmodule

### rtl/rbpl_link_ram.sv
// ---------------------------------------------------------------------------
// rbpl_link_ram
// LRU prev/next link banks, one port each, registered read.
// ---------------------------------------------------------------------------
module rbpl_link_ram import rbpl_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  link_ctl_t     ctl,
  input  logic [AW-1:0] prev_addr,
  input  logic [AW-1:0] prev_wdata,
  input  logic [AW-1:0] next_addr,
  input  logic [AW-1:0] next_wdata,
  output logic [AW-1:0] prev_rdata,
  output logic [AW-1:0] next_rdata
);

  logic [AW-1:0] prev_mem [DEPTH];
  logic [AW-1:0] next_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.prev_we) begin
      prev_mem[prev_addr] <= prev_wdata;
    end
    if (ctl.next_we) begin
      next_mem[next_addr] <= next_wdata;
    end
    if (ctl.rd) begin
      prev_rdata <= prev_mem[prev_addr];
      next_rdata <= next_mem[next_addr];
    end
  end

endmodule

### rtl/rbpl_stack.sv
// ---------------------------------------------------------------------------
// rbpl_stack
// Free-block stack RAM. Slots below the low-water mark were never written
// and read as their reset content (DEPTH-1-slot).
// ---------------------------------------------------------------------------
module rbpl_stack import rbpl_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ram_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [AW-1:0] wdata,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] mem_q;
  logic [AW-1:0] init_val_r;
  logic [CW-1:0] low_r;
  logic          init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= CW'(DEPTH);
      init_r <= 1'b0;
    end else if (ctl.rd) begin
      init_r <= (CW'(addr) < low_r);
      if (CW'(addr) < low_r) begin
        low_r <= CW'(addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      mem_q      <= mem[addr];
      init_val_r <= AW'(DEPTH - 1) - addr;
    end
  end

  assign rdata = init_r ? init_val_r : mem_q;

endmodule

### rtl/refcounted_block_pool_lru_top.sv
// ---------------------------------------------------------------------------
// refcounted_block_pool_lru_top
// Ref-counted cache block pool: free LIFO stack plus LRU list of cached
// blocks, with eviction of the LRU tail when the stack runs dry.
// ---------------------------------------------------------------------------
//
// Channel   Dir   Handshake            Payload
// in_if     in    valid/ready          operation, block_index, fill_count,
//                                      content_hash
// out_if    out   valid/ready          status .. eviction_total
// cfg       in    APB psel/penable     0x0 prefix_caching_enable, 0x4 tokens
//
// Steps: one item at a time. Accept, decode with the RAM read issued,
// block/link RAM read-modify-write, then the result load; the
// read-modify-write step is skipped when no block is read (out of pages,
// index past the pool). A relink to the LRU front (release into cache,
// touch) adds a step for the block's own links, and one more for prev[head]
// when the list is not empty.
// Reset: a zeroing sweep of the block RAM runs over all NUM_BLOCKS entries;
// no item is taken until it ends. Config writes are taken at any time.
// Stalls: the result register holds one item; the next item is accepted
// while it waits, and the pipeline halts at its last step until it drains.
// ---------------------------------------------------------------------------
module refcounted_block_pool_lru_top import rbpl_pkg::*; #(
  parameter int NUM_BLOCKS = 256,
  parameter int REF_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rbpl_in_if.sink     in_if,
  rbpl_out_if.source  out_if
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int BW = REF_WIDTH + FILL_W + HASH_W + 1;
  localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_RD, S_EVRD, S_POP, S_PF1, S_PF2, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // latched command
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [FILL_W-1:0] fin_r, fin_nxt;
  logic [HASH_W-1:0] hin_r, hin_nxt;
  logic [IW-1:0]     blk_r, blk_nxt;

  // config
  logic              pce_r, pce_nxt;
  logic [FILL_W-1:0] tpb_r, tpb_nxt;

  // pool bookkeeping
  logic [CW-1:0]     ftop_r, ftop_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic [EVT_W-1:0]  evc_r, evc_nxt;

  // pending result
  logic [STATUS_W-1:0] rst_st_r, rst_st_nxt;
  logic [IDX_W-1:0]    rblk_r, rblk_nxt;
  logic [REFO_W-1:0]   rref_r, rref_nxt;
  logic [FILL_W-1:0]   rfill_r, rfill_nxt;
  logic                rcach_r, rcach_nxt;
  logic                rev_r, rev_nxt;
  logic [HASH_W-1:0]   revh_r, revh_nxt;

  // output register
  logic                ov_r, ov_nxt;
  logic [STATUS_W-1:0] o_st_r, o_st_nxt;
  logic [IDX_W-1:0]    o_blk_r, o_blk_nxt;
  logic [REFO_W-1:0]   o_ref_r, o_ref_nxt;
  logic [FILL_W-1:0]   o_fill_r, o_fill_nxt;
  logic                o_cach_r, o_cach_nxt;
  logic                o_ev_r, o_ev_nxt;
  logic [HASH_W-1:0]   o_evh_r, o_evh_nxt;
  logic [CNTO_W-1:0]   o_free_r, o_free_nxt;
  logic [CNTO_W-1:0]   o_cnt_r, o_cnt_nxt;
  logic [EVT_W-1:0]    o_evt_r, o_evt_nxt;

  // memory ports
  ram_ctl_t      bm_ctl, st_ctl;
  link_ctl_t     ln_ctl;
  logic [IW-1:0] bm_addr, st_addr, st_wdata, st_rdata;
  logic [BW-1:0] bm_wdata, bm_rdata;
  logic          bm_busy;
  logic [IW-1:0] lp_addr, lp_wdata, lp_rdata, ln_addr, ln_wdata, ln_rdata;

  logic [REF_WIDTH-1:0] rd_ref;
  logic [FILL_W-1:0]    rd_fill;
  logic [HASH_W-1:0]    rd_hash;
  logic                 rd_cached;
  logic                 in_ready;
  logic                 cfg_we;

  assign {rd_ref, rd_fill, rd_hash, rd_cached} = bm_rdata;
  assign in_ready = (state_r == S_IDLE) && !bm_busy;
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2] == REG_TOKENS) prdata = 32'(tpb_r);
      else                        prdata = 32'(pce_r);
    end
  end

  rbpl_blk_ram #(.DEPTH(NUM_BLOCKS), .AW(IW), .DW(BW)) u_blk (
    .clk, .rst_n, .ctl(bm_ctl), .addr(bm_addr), .wdata(bm_wdata),
    .rdata(bm_rdata), .busy(bm_busy)
  );

  rbpl_link_ram #(.DEPTH(NUM_BLOCKS), .AW(IW)) u_link (
    .clk, .ctl(ln_ctl), .prev_addr(lp_addr), .prev_wdata(lp_wdata),
    .next_addr(ln_addr), .next_wdata(ln_wdata),
    .prev_rdata(lp_rdata), .next_rdata(ln_rdata)
  );

  rbpl_stack #(.DEPTH(NUM_BLOCKS), .AW(IW), .CW(CW)) u_stack (
    .clk, .rst_n, .ctl(st_ctl), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
  );

  always_comb begin
    logic [REF_WIDTH-1:0] nref;
    logic [FILL_W-1:0]    nfill;
    logic [HASH_W-1:0]    nhash;
    logic                 ncach;
    logic                 unlink;
    logic                 relink;
    logic                 to_stack;
    logic                 is_h;
    logic                 is_t;

    state_nxt = state_r;
    op_nxt = op_r;  idx_nxt = idx_r;  fin_nxt = fin_r;  hin_nxt = hin_r;
    blk_nxt = blk_r;
    pce_nxt = pce_r;  tpb_nxt = tpb_r;
    ftop_nxt = ftop_r;  len_nxt = len_r;  head_nxt = head_r;  tail_nxt = tail_r;
    evc_nxt = evc_r;
    rst_st_nxt = rst_st_r;  rblk_nxt = rblk_r;  rref_nxt = rref_r;
    rfill_nxt = rfill_r;  rcach_nxt = rcach_r;  rev_nxt = rev_r;  revh_nxt = revh_r;
    ov_nxt = ov_r && !out_if.ready;
    o_st_nxt = o_st_r;  o_blk_nxt = o_blk_r;  o_ref_nxt = o_ref_r;
    o_fill_nxt = o_fill_r;  o_cach_nxt = o_cach_r;  o_ev_nxt = o_ev_r;
    o_evh_nxt = o_evh_r;  o_free_nxt = o_free_r;  o_cnt_nxt = o_cnt_r;
    o_evt_nxt = o_evt_r;

    bm_ctl = '0;  bm_addr = blk_r;  bm_wdata = '0;
    st_ctl = '0;  st_addr = '0;  st_wdata = blk_r;
    ln_ctl = '0;  lp_addr = blk_r;  lp_wdata = blk_r;  ln_addr = blk_r;
    ln_wdata = head_r;

    nref = rd_ref;  nfill = rd_fill;  nhash = rd_hash;  ncach = rd_cached;
    unlink = 1'b0;  relink = 1'b0;  to_stack = 1'b0;
    is_h = (blk_r == head_r);
    is_t = (blk_r == tail_r);

    if (cfg_we) begin
      if (paddr[2] == REG_TOKENS) tpb_nxt = pwdata[FILL_W-1:0];
      else                        pce_nxt = pwdata[0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid && in_ready) begin
          op_nxt    = in_if.operation;
          idx_nxt   = in_if.block_index;
          fin_nxt   = in_if.fill_count;
          hin_nxt   = in_if.content_hash;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        rst_st_nxt = ST_OK;
        rblk_nxt   = idx_r;
        rref_nxt   = '0;
        rfill_nxt  = '0;
        rcach_nxt  = 1'b0;
        rev_nxt    = 1'b0;
        revh_nxt   = '0;
        if (op_r == OP_ALLOC) begin
          if (ftop_r == '0) begin
            if (len_r == '0) begin
              rst_st_nxt = ST_NOPAGE;
              rblk_nxt   = '0;
              state_nxt  = S_OUT;
            end else begin
              // stack empty: evict the LRU tail
              blk_nxt   = tail_r;
              bm_ctl.rd = 1'b1;
              bm_addr   = tail_r;
              ln_ctl.rd = 1'b1;
              lp_addr   = tail_r;
              ln_addr   = tail_r;
              state_nxt = S_EVRD;
            end
          end else begin
            st_ctl.rd = 1'b1;
            st_addr   = IW'(ftop_r - CW'(1));
            state_nxt = S_POP;
          end
        end else if (int'(idx_r) >= NUM_BLOCKS) begin
          state_nxt = S_OUT;
        end else begin
          blk_nxt   = IW'(idx_r);
          bm_ctl.rd = 1'b1;
          bm_addr   = IW'(idx_r);
          ln_ctl.rd = 1'b1;
          lp_addr   = IW'(idx_r);
          ln_addr   = IW'(idx_r);
          state_nxt = S_RD;
        end
      end

      S_EVRD: begin
        // the evicted tail bypasses the free stack: it is the new block
        rev_nxt   = 1'b1;
        revh_nxt  = rd_hash;
        bm_ctl.we = 1'b1;
        bm_wdata  = {REF_WIDTH'(1), FILL_W'(0), HASH_W'(0), 1'b0};
        if (!is_h) tail_nxt = lp_rdata;
        len_nxt   = len_r - CW'(1);
        evc_nxt   = evc_r + 1'b1;
        rblk_nxt  = IDX_W'(blk_r);
        rref_nxt  = REFO_W'(1);
        state_nxt = S_OUT;
      end

      S_POP: begin
        bm_ctl.we = 1'b1;
        bm_addr   = st_rdata;
        bm_wdata  = {REF_WIDTH'(1), FILL_W'(0), HASH_W'(0), 1'b0};
        ftop_nxt  = ftop_r - CW'(1);
        rblk_nxt  = IDX_W'(st_rdata);
        rref_nxt  = REFO_W'(1);
        state_nxt = S_OUT;
      end

      S_RD: begin
        case (op_r)
          OP_RELEASE: begin
            if (rd_ref == '0) begin
              rst_st_nxt = ST_REL_IGN;
            end else begin
              nref = rd_ref - 1'b1;
              if (nref == '0) begin
                if (pce_r && (rd_hash != '0)) begin
                  ncach  = 1'b1;
                  relink = 1'b1;
                end else begin
                  nfill    = '0;
                  to_stack = 1'b1;
                end
              end
            end
          end
          OP_RETAIN: begin
            if (rd_cached) begin
              unlink = 1'b1;
              ncach  = 1'b0;
              if (rd_ref != REF_MAX) nref = rd_ref + 1'b1;
            end else if ((rd_ref != '0) && (rd_ref != REF_MAX)) begin
              nref = rd_ref + 1'b1;
            end
          end
          OP_SET: begin
            nfill = (fin_r < tpb_r) ? fin_r : tpb_r;
            nhash = hin_r;
          end
          OP_TOUCH: begin
            if (rd_cached) begin
              unlink = 1'b1;
              relink = 1'b1;
            end
          end
          default: ;
        endcase

        bm_ctl.we = 1'b1;
        bm_wdata  = {nref, nfill, nhash, ncach};

        if (unlink) begin
          len_nxt = len_r - CW'(1);
          if (is_h && !is_t) head_nxt = ln_rdata;
          if (is_t && !is_h) tail_nxt = lp_rdata;
          if (!is_h && !is_t) begin
            // middle node: next[prev] = next, prev[next] = prev
            ln_ctl.next_we = 1'b1;
            ln_addr        = lp_rdata;
            ln_wdata       = ln_rdata;
            ln_ctl.prev_we = 1'b1;
            lp_addr        = ln_rdata;
            lp_wdata       = lp_rdata;
          end
        end

        if (to_stack && (int'(ftop_r) < NUM_BLOCKS)) begin
          st_ctl.we = 1'b1;
          st_addr   = IW'(ftop_r);
          ftop_nxt  = ftop_r + CW'(1);
        end

        rblk_nxt  = IDX_W'(blk_r);
        rref_nxt  = REFO_W'(nref);
        rfill_nxt = nfill;
        rcach_nxt = ncach;
        state_nxt = relink ? S_PF1 : S_OUT;
      end

      S_PF1: begin
        ln_ctl.prev_we = 1'b1;
        ln_ctl.next_we = 1'b1;
        if (len_r != '0) begin
          state_nxt = S_PF2;
        end else begin
          tail_nxt  = blk_r;
          head_nxt  = blk_r;
          len_nxt   = len_r + CW'(1);
          state_nxt = S_OUT;
        end
      end

      S_PF2: begin
        ln_ctl.prev_we = 1'b1;
        lp_addr        = head_r;
        head_nxt       = blk_r;
        len_nxt        = len_r + CW'(1);
        state_nxt      = S_OUT;
      end

      S_OUT: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt     = 1'b1;
          o_st_nxt   = rst_st_r;
          o_blk_nxt  = rblk_r;
          o_ref_nxt  = rref_r;
          o_fill_nxt = rfill_r;
          o_cach_nxt = rcach_r;
          o_ev_nxt   = rev_r;
          o_evh_nxt  = revh_r;
          o_free_nxt = CNTO_W'(ftop_r);
          o_cnt_nxt  = CNTO_W'(len_r);
          o_evt_nxt  = evc_r;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pce_r   <= 1'b1;
      tpb_r   <= FILL_W'(16);
      ftop_r  <= CW'(NUM_BLOCKS);
      len_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      evc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pce_r   <= pce_nxt;
      tpb_r   <= tpb_nxt;
      ftop_r  <= ftop_nxt;
      len_r   <= len_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      evc_r   <= evc_nxt;
      ov_r    <= ov_nxt;
    end
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    fin_r    <= fin_nxt;
    hin_r    <= hin_nxt;
    blk_r    <= blk_nxt;
    rst_st_r <= rst_st_nxt;
    rblk_r   <= rblk_nxt;
    rref_r   <= rref_nxt;
    rfill_r  <= rfill_nxt;
    rcach_r  <= rcach_nxt;
    rev_r    <= rev_nxt;
    revh_r   <= revh_nxt;
    o_st_r   <= o_st_nxt;
    o_blk_r  <= o_blk_nxt;
    o_ref_r  <= o_ref_nxt;
    o_fill_r <= o_fill_nxt;
    o_cach_r <= o_cach_nxt;
    o_ev_r   <= o_ev_nxt;
    o_evh_r  <= o_evh_nxt;
    o_free_r <= o_free_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_evt_r  <= o_evt_nxt;
  end

  assign in_if.ready           = in_ready;
  assign out_if.valid          = ov_r;
  assign out_if.status         = o_st_r;
  assign out_if.result_block   = o_blk_r;
  assign out_if.ref_after      = o_ref_r;
  assign out_if.fill_after     = o_fill_r;
  assign out_if.cached_after   = o_cach_r;
  assign out_if.evicted        = o_ev_r;
  assign out_if.evicted_hash   = o_evh_r;
  assign out_if.free_count     = o_free_r;
  assign out_if.cached_blocks  = o_cnt_r;
  assign out_if.eviction_total = o_evt_r;

endmodule
